// ===== rtl/aad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aad_pkg
// types and constants for the area averaging image downscaler
// ----------------------------------------------------------------------------
package aad_pkg;

	localparam int unsigned MAX_SRC_DIM   = 4096;
	localparam int unsigned MAX_DST_WIDTH = 1024;
	localparam int unsigned CHANNELS      = 4;

	localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TARGET_WIDTH  = 2'd2;
	localparam logic [1:0] REG_TARGET_HEIGHT = 2'd3;

	typedef struct packed {
		logic [31:0] src_pixel;
		logic        frame_start;
	} in_word_t;

	typedef struct packed {
		logic [31:0] dst_pixel;
		logic [9:0]  dst_col;
		logic [11:0] dst_row;
		logic        frame_last;
	} out_word_t;

endpackage
`default_nettype wire

// ===== rtl/area_average_image_downscaler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// area_average_image_downscaler
// box filter downscale of a raster pixel stream with a column sum line store
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// in        in   in_valid / in_stall    aad_pkg::in_word_t
// out       out  out_valid / out_stall  aad_pkg::out_word_t
// cfg       in   cfg_we                 cfg_index, cfg_data
//
// one word is worked on at a time: accept, two set-up steps and finish, plus
// a multiply-accumulate, check and advance step per channel; a finished column
// adds a division and vertical sum per channel, a finished row a further division
// per channel, all through one shared bit serial divider.
// reset needs no clearing pass: line store entries are only read after the
// first source row of a frame has written them.
// a waiting result sits in the output register; only its replacement waits.
// ----------------------------------------------------------------------------
module area_average_image_downscaler (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  aad_pkg::in_word_t    in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output aad_pkg::out_word_t   out_data,
	input  wire                  cfg_we,
	input  wire [1:0]            cfg_index,
	input  wire [12:0]           cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL, ST_FLAG, ST_HMAC, ST_HCHK, ST_HDIV,
		ST_VMAC, ST_VCHK, ST_VDIV, ST_NEXT, ST_FIN
	} state_t;

	state_t state_q;

	logic [12:0] sw_q, sh_q;
	logic [10:0] tw_q;
	logic [12:0] th_q;

	logic [11:0] col_q, row_q, drow_q;
	logic [9:0]  mid_q;

	logic [31:0] pix_q, outpix_q;
	logic [1:0]  ch_q;
	logic [23:0] xs_q, bx_q;
	logic [25:0] ys_q, by_q;
	logic [10:0] p1_q, p2_q;
	logic [12:0] v1_q, v2_q;
	logic        coldone_q, rowdone_q;
	logic [19:0] acc_q, vacc_q;
	logic [7:0]  q_q;
	logic [19:0] rs_q [aad_pkg::CHANNELS];

	// line store
	logic [19:0] mem [aad_pkg::MAX_DST_WIDTH * aad_pkg::CHANNELS];
	logic [19:0] rd_q;
	logic        mem_we;
	logic [11:0] mem_addr;
	logic [19:0] mem_wdata;

	// divider
	logic [21:0] dnum_q, dquo_q;
	logic [13:0] dden_q, drem_q;
	logic [4:0]  dcnt_q;
	logic [14:0] dtrial;
	logic        dfit;
	logic [7:0]  dsat;

	logic        out_valid_q;
	aad_pkg::out_word_t out_q;

	// effective sizes
	logic [12:0] ws, hs, ht, wlim;
	logic [10:0] wt;

	always_comb begin
		ws = (sw_q == 13'd0) ? 13'd1 :
			(sw_q > 13'(aad_pkg::MAX_SRC_DIM)) ? 13'(aad_pkg::MAX_SRC_DIM) : sw_q;
		hs = (sh_q == 13'd0) ? 13'd1 :
			(sh_q > 13'(aad_pkg::MAX_SRC_DIM)) ? 13'(aad_pkg::MAX_SRC_DIM) : sh_q;
		wlim = (ws < 13'(aad_pkg::MAX_DST_WIDTH)) ? ws : 13'(aad_pkg::MAX_DST_WIDTH);
		wt = (tw_q == 11'd0) ? 11'd1 : ({2'b0, tw_q} > wlim) ? wlim[10:0] : tw_q;
		ht = (th_q == 13'd0) ? 13'd1 : (th_q > hs) ? hs : th_q;
	end

	logic        restart;
	logic [7:0]  val;
	logic [19:0] rs_sel, acc_sum, vacc_sum;
	logic [23:0] xe;
	logic [25:0] ye;
	logic [12:0] col_inc, row_inc;
	logic [10:0] mid_inc;

	always_comb begin
		restart = in_data.frame_start || ({1'b0, col_q} >= ws) || ({1'b0, row_q} >= hs) ||
			({1'b0, mid_q} >= wt) || ({1'b0, drow_q} >= ht);
		val = pix_q[ch_q * 8 +: 8];
		rs_sel = (col_q == 12'd0) ? 20'd0 : rs_q[ch_q];
		acc_sum = rs_sel + 20'(val * p1_q);
		vacc_sum = ((row_q == 12'd0) ? 20'd0 : rd_q) + 20'(q_q * v1_q);
		xe = xs_q + 24'(wt);
		ye = ys_q + 26'(ht);
		col_inc = {1'b0, col_q} + 13'd1;
		row_inc = {1'b0, row_q} + 13'd1;
		mid_inc = {1'b0, mid_q} + 11'd1;
		dtrial = {drem_q, dnum_q[21]};
		dfit = dtrial >= {1'b0, dden_q};
		dsat = (dquo_q > 22'd255) ? 8'd255 : dquo_q[7:0];
		mem_addr = {mid_q, ch_q};
		mem_we = 1'b0;
		mem_wdata = vacc_q;
		if (state_q == ST_VCHK && !rowdone_q) begin
			mem_we = 1'b1;
		end
		if (state_q == ST_VDIV && dcnt_q == 5'd0) begin
			mem_we = 1'b1;
			mem_wdata = 20'(q_q * v2_q);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (state_q == ST_HMAC) begin
			rd_q <= mem[mem_addr];
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sw_q <= 13'd1;
			sh_q <= 13'd1;
			tw_q <= 11'd1;
			th_q <= 13'd1;
			col_q <= '0;
			row_q <= '0;
			mid_q <= '0;
			drow_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					aad_pkg::REG_SOURCE_WIDTH:  sw_q <= cfg_data;
					aad_pkg::REG_SOURCE_HEIGHT: sh_q <= cfg_data;
					aad_pkg::REG_TARGET_WIDTH:  tw_q <= cfg_data[10:0];
					aad_pkg::REG_TARGET_HEIGHT: th_q <= cfg_data;
					default: ;
				endcase
				col_q <= '0;
				row_q <= '0;
				mid_q <= '0;
				drow_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pix_q <= in_data.src_pixel;
						outpix_q <= '0;
						if (restart) begin
							col_q <= '0;
							row_q <= '0;
							mid_q <= '0;
							drow_q <= '0;
						end
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					xs_q <= 24'(col_q * wt);
					bx_q <= 24'(mid_inc * ws);
					ys_q <= 26'(row_q * ht);
					by_q <= 26'(({1'b0, drow_q} + 13'd1) * hs);
					state_q <= ST_FLAG;
				end
				ST_FLAG: begin
					if (xe <= bx_q) begin
						p1_q <= wt;
						p2_q <= '0;
					end else if (bx_q > xs_q) begin
						p1_q <= 11'(bx_q - xs_q);
						p2_q <= wt - 11'(bx_q - xs_q);
					end else begin
						p1_q <= '0;
						p2_q <= wt;
					end
					coldone_q <= xe >= bx_q;
					if (ye <= by_q) begin
						v1_q <= ht;
						v2_q <= '0;
					end else if (by_q > ys_q) begin
						v1_q <= 13'(by_q - ys_q);
						v2_q <= ht - 13'(by_q - ys_q);
					end else begin
						v1_q <= '0;
						v2_q <= ht;
					end
					rowdone_q <= ye >= by_q;
					ch_q <= '0;
					state_q <= ST_HMAC;
				end
				ST_HMAC: begin
					acc_q <= acc_sum;
					state_q <= ST_HCHK;
				end
				ST_HCHK: begin
					if (!coldone_q) begin
						rs_q[ch_q] <= acc_q;
						state_q <= ST_NEXT;
					end else begin
						dnum_q <= {1'b0, acc_q, 1'b0} + 22'(ws);
						dden_q <= {ws, 1'b0};
						drem_q <= '0;
						dquo_q <= '0;
						dcnt_q <= 5'd22;
						state_q <= ST_HDIV;
					end
				end
				ST_HDIV: begin
					if (dcnt_q != 5'd0) begin
						drem_q <= dfit ? 14'(dtrial - {1'b0, dden_q}) : dtrial[13:0];
						dquo_q <= {dquo_q[20:0], dfit};
						dnum_q <= {dnum_q[20:0], 1'b0};
						dcnt_q <= dcnt_q - 5'd1;
					end else begin
						q_q <= dsat;
						rs_q[ch_q] <= 20'(val * p2_q);
						state_q <= ST_VMAC;
					end
				end
				ST_VMAC: begin
					vacc_q <= vacc_sum;
					state_q <= ST_VCHK;
				end
				ST_VCHK: begin
					if (!rowdone_q) begin
						state_q <= ST_NEXT;
					end else begin
						dnum_q <= {1'b0, vacc_q, 1'b0} + 22'(hs);
						dden_q <= {hs, 1'b0};
						drem_q <= '0;
						dquo_q <= '0;
						dcnt_q <= 5'd22;
						state_q <= ST_VDIV;
					end
				end
				ST_VDIV: begin
					if (dcnt_q != 5'd0) begin
						drem_q <= dfit ? 14'(dtrial - {1'b0, dden_q}) : dtrial[13:0];
						dquo_q <= {dquo_q[20:0], dfit};
						dnum_q <= {dnum_q[20:0], 1'b0};
						dcnt_q <= dcnt_q - 5'd1;
					end else begin
						outpix_q[ch_q * 8 +: 8] <= dsat;
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (ch_q == 2'(aad_pkg::CHANNELS - 1)) begin
						state_q <= ST_FIN;
					end else begin
						ch_q <= ch_q + 2'd1;
						state_q <= ST_HMAC;
					end
				end
				ST_FIN: begin
					// hold here until the output register can take the word
					if (!(coldone_q && rowdone_q && out_valid_q && out_stall)) begin
						if (coldone_q && rowdone_q) begin
							out_q.dst_pixel <= outpix_q;
							out_q.dst_col <= mid_q;
							out_q.dst_row <= drow_q;
							out_q.frame_last <= (mid_inc == wt) &&
								({1'b0, drow_q} + 13'd1 == ht);
							out_valid_q <= 1'b1;
						end
						if (col_inc >= ws) begin
							col_q <= '0;
							mid_q <= '0;
							if (row_inc >= hs) begin
								row_q <= '0;
								drow_q <= '0;
							end else begin
								row_q <= row_inc[11:0];
								if (rowdone_q) begin
									drow_q <= drow_q + 12'd1;
								end
							end
						end else begin
							col_q <= col_inc[11:0];
							if (coldone_q) begin
								mid_q <= mid_inc[9:0];
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
